// File: hw/rtl/two_operand_decimal_calculator_top_macros.svh
// assertion helpers for the calculator top level
// both sample on the rising clock edge and are off while reset is high
`ifndef TWO_OPERAND_DECIMAL_CALCULATOR_TOP_MACROS_SVH
`define TWO_OPERAND_DECIMAL_CALCULATOR_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TDC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tdc_pkg.sv
`default_nettype none

package tdc_pkg;

   // fixed widths of the channel fields
   localparam int RESULT_WIDTH = 32;
   localparam int CHAR_WIDTH   = 8;

   // characters the parser knows
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_STAR    = 8'h2A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;

   // operator codes
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_REM
   } tdc_op_type;

   // parser phases
   typedef enum logic [2:0] {
      PH_LEAD1,
      PH_DIG1,
      PH_MID,
      PH_LEAD2,
      PH_DIG2,
      PH_DONE
   } tdc_phase_type;

   // sequencer states of the arithmetic unit
   typedef enum logic [3:0] {
      ALU_IDLE,
      ALU_NEG_A,
      ALU_NEG_B,
      ALU_SUM,
      ALU_ABS_A,
      ALU_ABS_B,
      ALU_ITER,
      ALU_FIX,
      ALU_DONE
   } tdc_alu_state_type;

   // signs and operator handed from parser to arithmetic unit
   typedef struct packed {
      logic       first_negative;
      logic       second_negative;
      tdc_op_type op;
   } tdc_ctrl_type;

   function automatic tdc_op_type op_of(input logic [CHAR_WIDTH-1:0] c);
      tdc_op_type op;
      case (c)
         CHAR_PLUS:    op = OP_ADD;
         CHAR_MINUS:   op = OP_SUB;
         CHAR_STAR:    op = OP_MUL;
         CHAR_SLASH:   op = OP_DIV;
         CHAR_PERCENT: op = OP_REM;
         default:      op = OP_NONE;
      endcase
      return op;
   endfunction

   function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tdc_parser.sv
`default_nettype none

module tdc_parser
   import tdc_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  char_accept,
   input  wire logic [CHAR_WIDTH-1:0] char_code,
   input  wire logic                  end_of_line,
   output logic      [WORD_WIDTH-1:0] first_value,
   output logic      [WORD_WIDTH-1:0] second_value,
   output tdc_ctrl_type               ctrl
);

   tdc_phase_type         phase_ff, phase_in;
   logic                  first_negative_ff, first_negative_in;
   logic [WORD_WIDTH-1:0] first_value_ff, first_value_in;
   tdc_op_type            op_ff, op_in;
   logic                  second_negative_ff, second_negative_in;
   logic [WORD_WIDTH-1:0] second_value_ff, second_value_in;
   logic                  consumed;

   // value times ten plus the digit, wrapping at the word width
   function automatic logic [WORD_WIDTH-1:0] acc_digit(input logic [WORD_WIDTH-1:0] v,
                                                       input logic [CHAR_WIDTH-1:0] c);
      return (v << 3) + (v << 1) + {{(WORD_WIDTH-4){1'b0}}, c[3:0]};
   endfunction

   // phase register and operand state
   always_ff @(posedge clock) begin
      if (reset || (char_accept && end_of_line)) begin
         phase_ff           <= PH_LEAD1;
         first_negative_ff  <= 1'b0;
         first_value_ff     <= '0;
         op_ff              <= OP_NONE;
         second_negative_ff <= 1'b0;
         second_value_ff    <= '0;
      end else if (char_accept) begin
         phase_ff           <= phase_in;
         first_negative_ff  <= first_negative_in;
         first_value_ff     <= first_value_in;
         op_ff              <= op_in;
         second_negative_ff <= second_negative_in;
         second_value_ff    <= second_value_in;
      end
   end

   // one character; a phase that does not take it hands it on to the next
   always_comb begin
      phase_in           = phase_ff;
      first_negative_in  = first_negative_ff;
      first_value_in     = first_value_ff;
      op_in              = op_ff;
      second_negative_in = second_negative_ff;
      second_value_in    = second_value_ff;
      consumed           = 1'b0;

      // leading spaces and sign of the first number
      if (phase_in == PH_LEAD1) begin
         if (char_code == CHAR_SPACE) begin
            consumed = 1'b1;
         end else begin
            phase_in = PH_DIG1;
            if (char_code == CHAR_MINUS) begin
               first_negative_in = 1'b1;
               consumed          = 1'b1;
            end
         end
      end

      // digits of the first number
      if (!consumed && phase_in == PH_DIG1) begin
         if (is_digit(char_code)) begin
            first_value_in = acc_digit(first_value_ff, char_code);
            consumed       = 1'b1;
         end else begin
            phase_in = PH_MID;
         end
      end

      // spaces and operator
      if (!consumed && phase_in == PH_MID) begin
         consumed = 1'b1;
         if (char_code != CHAR_SPACE) begin
            op_in    = op_of(char_code);
            phase_in = (op_in != OP_NONE) ? PH_LEAD2 : PH_DONE;
         end
      end

      // leading spaces and sign of the second number
      if (!consumed && phase_in == PH_LEAD2) begin
         if (char_code == CHAR_SPACE) begin
            consumed = 1'b1;
         end else begin
            phase_in = PH_DIG2;
            if (char_code == CHAR_MINUS) begin
               second_negative_in = 1'b1;
               consumed           = 1'b1;
            end
         end
      end

      // digits of the second number
      if (!consumed && phase_in == PH_DIG2) begin
         if (is_digit(char_code)) begin
            second_value_in = acc_digit(second_value_ff, char_code);
         end else begin
            phase_in = PH_DONE;
         end
      end
   end

   // values after this character, used when it ends the line
   assign first_value          = first_value_in;
   assign second_value         = second_value_in;
   assign ctrl.first_negative  = first_negative_in;
   assign ctrl.second_negative = second_negative_in;
   assign ctrl.op              = op_in;

endmodule

`default_nettype wire

// File: hw/rtl/tdc_alu.sv
`default_nettype none

module tdc_alu
   import tdc_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WORD_WIDTH-1:0] first_value,
   input  wire logic [WORD_WIDTH-1:0] second_value,
   input  wire tdc_ctrl_type          ctrl,
   input  wire logic                  take,
   output logic                       busy,
   output logic                       done,
   output logic      [WORD_WIDTH-1:0] result
);

   localparam int CNT_WIDTH = $clog2(WORD_WIDTH + 1);

   tdc_alu_state_type     state_ff, state_in;
   tdc_op_type            op_ff, op_in;
   logic                  neg_a_ff, neg_a_in;
   logic                  neg_b_ff, neg_b_in;
   logic [WORD_WIDTH-1:0] opa_ff, opa_in;
   logic [WORD_WIDTH-1:0] opb_ff, opb_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;

   // shared adder: x + y or x - y, carry out means x >= y on subtract
   logic [WORD_WIDTH:0]   add_x, add_y;
   logic                  add_sub;
   logic [WORD_WIDTH+1:0] add_sum;
   logic                  add_carry;

   assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(WORD_WIDTH+1){add_sub}}}
                    + {{(WORD_WIDTH+1){1'b0}}, add_sub};
   assign add_carry = add_sum[WORD_WIDTH+1];

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      acc_ff   <= acc_in;
      count_ff <= count_in;
   end

   // adder operands per step
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         ALU_NEG_A: begin
            add_y   = {1'b0, opa_ff};
            add_sub = neg_a_ff;
         end
         ALU_NEG_B: begin
            add_y   = {1'b0, opb_ff};
            add_sub = neg_b_ff;
         end
         ALU_SUM: begin
            add_x   = {1'b0, opa_ff};
            add_y   = {1'b0, opb_ff};
            add_sub = (op_ff == OP_SUB);
         end
         ALU_ABS_A: begin
            add_y   = {1'b0, opa_ff};
            add_sub = opa_ff[WORD_WIDTH-1];
         end
         ALU_ABS_B: begin
            add_y   = {1'b0, opb_ff};
            add_sub = opb_ff[WORD_WIDTH-1];
         end
         ALU_ITER: begin
            if (op_ff == OP_MUL) begin
               add_x = {1'b0, acc_ff};
               add_y = {1'b0, opa_ff};
            end else begin
               add_x   = {acc_ff, opa_ff[WORD_WIDTH-1]};
               add_y   = {1'b0, opb_ff};
               add_sub = 1'b1;
            end
         end
         ALU_FIX: begin
            if (op_ff == OP_DIV) begin
               add_y   = {1'b0, opa_ff};
               add_sub = neg_a_ff ^ neg_b_ff;
            end else begin
               add_y   = {1'b0, acc_ff};
               add_sub = neg_a_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      unique case (state_ff)
         ALU_IDLE: begin
            if (start) begin
               opa_in   = first_value;
               opb_in   = second_value;
               neg_a_in = ctrl.first_negative;
               neg_b_in = ctrl.second_negative;
               op_in    = ctrl.op;
               state_in = ALU_NEG_A;
            end
         end
         // apply the parsed signs
         ALU_NEG_A: begin
            opa_in   = add_sum[WORD_WIDTH-1:0];
            state_in = ALU_NEG_B;
         end
         ALU_NEG_B: begin
            opb_in   = add_sum[WORD_WIDTH-1:0];
            acc_in   = '0;
            count_in = CNT_WIDTH'(WORD_WIDTH);
            priority case (op_ff)
               OP_MUL:        state_in = ALU_ITER;
               OP_DIV, OP_REM: state_in = ALU_ABS_A;
               default:       state_in = ALU_SUM;
            endcase
         end
         // sum, difference or the first operand alone
         ALU_SUM: begin
            acc_in   = (op_ff == OP_NONE) ? opa_ff : add_sum[WORD_WIDTH-1:0];
            state_in = ALU_DONE;
         end
         // magnitudes for division, signs kept for the fix-up
         ALU_ABS_A: begin
            neg_a_in = opa_ff[WORD_WIDTH-1];
            opa_in   = add_sum[WORD_WIDTH-1:0];
            state_in = ALU_ABS_B;
         end
         ALU_ABS_B: begin
            neg_b_in = opb_ff[WORD_WIDTH-1];
            opb_in   = add_sum[WORD_WIDTH-1:0];
            state_in = ALU_ITER;
         end
         // one bit per cycle: shift-add multiply or restoring divide
         ALU_ITER: begin
            count_in = count_ff - CNT_WIDTH'(1);
            if (op_ff == OP_MUL) begin
               if (opb_ff[0]) begin
                  acc_in = add_sum[WORD_WIDTH-1:0];
               end
               opa_in = opa_ff << 1;
               opb_in = opb_ff >> 1;
            end else begin
               acc_in = add_carry ? add_sum[WORD_WIDTH-1:0]
                                  : {acc_ff[WORD_WIDTH-2:0], opa_ff[WORD_WIDTH-1]};
               opa_in = {opa_ff[WORD_WIDTH-2:0], add_carry};
            end
            if (count_ff == CNT_WIDTH'(1)) begin
               state_in = (op_ff == OP_MUL) ? ALU_DONE : ALU_FIX;
            end
         end
         // signed quotient or remainder, zero divisor gives zero
         ALU_FIX: begin
            acc_in   = (opb_ff == '0) ? '0 : add_sum[WORD_WIDTH-1:0];
            state_in = ALU_DONE;
         end
         ALU_DONE: begin
            if (take) begin
               state_in = ALU_IDLE;
            end
         end
         default: begin
            state_in = ALU_IDLE;
         end
      endcase
   end

   assign busy   = (state_ff != ALU_IDLE);
   assign done   = (state_ff == ALU_DONE);
   assign result = acc_ff;

endmodule

`default_nettype wire

// File: hw/rtl/two_operand_decimal_calculator_top.sv
// Two-operand decimal calculator.
// req channel: one ASCII character per transfer (req_char_code) with
// req_end_of_line marking the last character of an expression.
// rsp channel: one signed 32-bit rsp_result per line, sent after the
// transfer that carries req_end_of_line; other characters give no result.
// Ordinary characters are taken one per cycle and do not raise req_stall.
// After an end-of-line transfer the shared add/shift unit evaluates the
// expression and req_stall stays high until the result is in the output
// register. The signs are applied first; then one add or subtract serves
// no operator, + and -, while * runs a shift-add loop and / and % a
// restoring divide loop with a sign fix-up, one bit per cycle.
// If rsp_stall holds a previous result, characters are still taken;
// a finished evaluation waits in the unit, and input stays stalled.
// Arithmetic wraps at WORD_WIDTH bits, then is sign-extended or cut to 32.
// Synchronous reset clears the parser, the unit and the output valid.
`default_nettype none

`include "two_operand_decimal_calculator_top_macros.svh"

module two_operand_decimal_calculator_top
   import tdc_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic        [CHAR_WIDTH-1:0]   req_char_code,
   input  wire logic                           req_end_of_line,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed      [RESULT_WIDTH-1:0] rsp_result
);

   logic                    req_accept;
   logic [WORD_WIDTH-1:0]   first_value;
   logic [WORD_WIDTH-1:0]   second_value;
   tdc_ctrl_type            ctrl;
   logic                    alu_busy;
   logic                    alu_done;
   logic [WORD_WIDTH-1:0]   alu_result;
   logic                    alu_take;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_result_ff, rsp_result_in;

   assign req_stall  = alu_busy;
   assign req_accept = req_valid && !req_stall;

   tdc_parser #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .char_accept (req_accept),
      .char_code   (req_char_code),
      .end_of_line (req_end_of_line),
      .first_value (first_value),
      .second_value(second_value),
      .ctrl        (ctrl)
   );

   tdc_alu #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_alu (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept && req_end_of_line),
      .first_value (first_value),
      .second_value(second_value),
      .ctrl        (ctrl),
      .take        (alu_take),
      .busy        (alu_busy),
      .done        (alu_done),
      .result      (alu_result)
   );

   // fit the word to the result width
   if (WORD_WIDTH >= RESULT_WIDTH) begin : g_cut
      assign rsp_result_in = alu_result[RESULT_WIDTH-1:0];
   end else begin : g_extend
      assign rsp_result_in = {{(RESULT_WIDTH-WORD_WIDTH){alu_result[WORD_WIDTH-1]}},
                              alu_result};
   end

   // output register, loaded when empty or emptied this cycle
   assign alu_take     = alu_done && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = alu_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alu_take) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // checks
   `TDC_ASSERT_NEXT(a_eol_starts_unit, req_accept && req_end_of_line, alu_busy, "end of line did not start evaluation")
   `TDC_ASSERT_NEXT(a_char_no_result, req_accept && !req_end_of_line && !rsp_valid, !rsp_valid, "result without end of line")
   `TDC_ASSERT_NEXT(a_done_waits, alu_done && rsp_valid && rsp_stall, alu_done && $stable(alu_result), "finished result lost while output full")
   `TDC_ASSERT_NOW(a_rsp_from_unit, $rose(rsp_valid), $past(alu_done), "output valid without finished evaluation")

endmodule

`default_nettype wire

// File: verif/tdc_result_checker.sv
`timescale 1ns / 1ps

module tdc_result_checker
   import tdc_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic        [CHAR_WIDTH-1:0]   req_char_code,
   input  wire logic                           req_end_of_line,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic signed [RESULT_WIDTH-1:0] rsp_result,
   output int                                  fail_count,
   output int                                  values_pending,
   output int                                  values_checked,
   output logic             [5:0]              operators_seen
);

   // parser mirror
   tdc_phase_type          phase;
   logic                   first_neg;
   logic [WORD_WIDTH-1:0]  first_mag;
   tdc_op_type             line_op;
   logic                   second_neg;
   logic [WORD_WIDTH-1:0]  second_mag;

   // values of finished lines still owed by the block
   logic signed [RESULT_WIDTH-1:0] predicted_values [$];

   initial begin
      fail_count     = 0;
      values_pending = 0;
      values_checked = 0;
      operators_seen = '0;
   end

   task automatic report_error(input string msg);
      $display("[%0t] calculator mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic clear_line();
      phase      = PH_LEAD1;
      first_neg  = 1'b0;
      first_mag  = '0;
      line_op    = OP_NONE;
      second_neg = 1'b0;
      second_mag = '0;
   endtask

   function automatic tdc_op_type operator_for(input logic [CHAR_WIDTH-1:0] c);
      case (c)
         CHAR_PLUS:    return OP_ADD;
         CHAR_MINUS:   return OP_SUB;
         CHAR_STAR:    return OP_MUL;
         CHAR_SLASH:   return OP_DIV;
         CHAR_PERCENT: return OP_REM;
         default:      return OP_NONE;
      endcase
   endfunction

   // one character through the parser; a character that ends a phase is
   // looked at again by the next phase
   task automatic take_char(input logic [CHAR_WIDTH-1:0] c);
      logic again;
      logic digit;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (phase)
            PH_LEAD1: begin
               if (c != CHAR_SPACE) begin
                  phase = PH_DIG1;
                  if (c == CHAR_MINUS) first_neg = 1'b1;
                  else again = 1'b1;
               end
            end
            PH_DIG1: begin
               if (digit) begin
                  first_mag = first_mag * 10 + WORD_WIDTH'(c - CHAR_ZERO);
               end else begin
                  phase = PH_MID;
                  again = 1'b1;
               end
            end
            PH_MID: begin
               if (c != CHAR_SPACE) begin
                  line_op = operator_for(c);
                  phase   = (line_op != OP_NONE) ? PH_LEAD2 : PH_DONE;
               end
            end
            PH_LEAD2: begin
               if (c != CHAR_SPACE) begin
                  phase = PH_DIG2;
                  if (c == CHAR_MINUS) second_neg = 1'b1;
                  else again = 1'b1;
               end
            end
            PH_DIG2: begin
               if (digit) second_mag = second_mag * 10 + WORD_WIDTH'(c - CHAR_ZERO);
               else phase = PH_DONE;
            end
            default: ;
         endcase
      end
   endtask

   // value of the line, wrapped to the word width
   function automatic logic [WORD_WIDTH-1:0] line_value();
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
      logic [WORD_WIDTH-1:0] ma;
      logic [WORD_WIDTH-1:0] mb;
      logic [WORD_WIDTH-1:0] q;
      a  = first_neg ? -first_mag : first_mag;
      b  = second_neg ? -second_mag : second_mag;
      ma = a[WORD_WIDTH-1] ? -a : a;
      mb = b[WORD_WIDTH-1] ? -b : b;
      case (line_op)
         OP_ADD: return a + b;
         OP_SUB: return a - b;
         OP_MUL: return a * b;
         OP_DIV: begin
            if (b == '0) return '0;
            q = ma / mb;
            return (a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1]) ? -q : q;
         end
         OP_REM: begin
            if (b == '0) return '0;
            q = ma % mb;
            return a[WORD_WIDTH-1] ? -q : q;
         end
         default: return a;
      endcase
   endfunction

   // watch both channels at each edge
   always @(posedge clock) begin : track
      logic [WORD_WIDTH-1:0]          wide;
      logic signed [RESULT_WIDTH-1:0] want;
      if (reset) begin
         clear_line();
         predicted_values.delete();
      end else begin
         // character transfer
         if (req_valid && !req_stall) begin
            take_char(req_char_code);
            if (req_end_of_line) begin
               wide = line_value();
               predicted_values.push_back(RESULT_WIDTH'($signed(wide)));
               operators_seen[line_op] = 1'b1;
               clear_line();
            end
         end
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            if (predicted_values.size() == 0) begin
               report_error($sformatf("result %0d with no line pending", rsp_result));
            end else begin
               want = predicted_values.pop_front();
               if (rsp_result !== want)
                  report_error($sformatf("result %0d, predicted %0d", rsp_result, want));
               values_checked++;
            end
         end
      end
      values_pending = predicted_values.size();
   end

   initial clear_line();

endmodule

// File: verif/two_operand_decimal_calculator_top_tb.sv
`timescale 1ns / 1ps

module two_operand_decimal_calculator_top_tb;
   import tdc_pkg::*;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic        [CHAR_WIDTH-1:0]   req_char_code = '0;
   logic                           req_end_of_line = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [RESULT_WIDTH-1:0] rsp_result;

   int         fail_count;
   int         values_pending;
   int         values_checked;
   logic [5:0] operators_seen;

   // characters of the line being built, and transfer bookkeeping
   byte unsigned line_chars [$];
   int           chars_sent = 0;
   int           burst_left = 0;

   string extreme_numbers [8] = '{"0", "1", "10", "2147483647", "2147483648",
                                  "4294967295", "4294967296", "99999999999"};
   string directed_lines [8] = '{"5+3", "2-9", "-6*7", "-7/2", "-7%2", "5/0",
                                 "-", "+4"};

   two_operand_decimal_calculator_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result)
   );

   tdc_result_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .fail_count      (fail_count),
      .values_pending  (values_pending),
      .values_checked  (values_checked),
      .operators_seen  (operators_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // send the line in line_chars, flagging its last character
   task automatic send_line();
      int gap;
      foreach (line_chars[i]) begin
         req_valid       <= 1'b1;
         req_char_code   <= line_chars[i];
         req_end_of_line <= (i == line_chars.size() - 1);
         @(posedge clock);
         while (req_stall) @(posedge clock);
         chars_sent++;
         burst_left--;
         // end of a burst: idle a while with junk on the payload
         if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(1, 6);
            req_valid       <= 1'b0;
            req_char_code   <= CHAR_WIDTH'($urandom);
            req_end_of_line <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // decimal operand, mostly short, sometimes long or an extreme value
   task automatic add_number();
      int    pick;
      string s;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         s = extreme_numbers[$urandom_range(0, 7)];
         for (int k = 0; k < s.len(); k++) line_chars.push_back(s[k]);
      end else begin
         repeat ((pick < 30) ? $urandom_range(4, 11) : $urandom_range(0, 3))
            line_chars.push_back(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
      end
   endtask

   // random line: mostly well formed expressions, some noise
   task automatic build_line();
      line_chars.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 6)) line_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) line_chars.push_back(CHAR_SPACE);
         if ($urandom_range(0, 3) == 0) line_chars.push_back(CHAR_MINUS);
         add_number();
         repeat ($urandom_range(0, 2)) line_chars.push_back(CHAR_SPACE);
         if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 4))
               0:       line_chars.push_back(CHAR_PLUS);
               1:       line_chars.push_back(CHAR_MINUS);
               2:       line_chars.push_back(CHAR_STAR);
               3:       line_chars.push_back(CHAR_SLASH);
               default: line_chars.push_back(CHAR_PERCENT);
            endcase
            repeat ($urandom_range(0, 2)) line_chars.push_back(CHAR_SPACE);
            if ($urandom_range(0, 3) == 0) line_chars.push_back(CHAR_MINUS);
            add_number();
         end
         // stray terminator or junk, parsed or ignored depending on phase
         if ($urandom_range(0, 7) == 0)
            line_chars.push_back(($urandom_range(0, 1) == 0) ? 8'h00
                                 : CHAR_WIDTH'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
               line_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
         end
         if (line_chars.size() == 0) line_chars.push_back(CHAR_SPACE);
      end
   endtask

   // stimulus and verdict
   initial begin
      string s;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed lines: each operator, signs, division by zero, lone minus
      foreach (directed_lines[j]) begin
         s = directed_lines[j];
         line_chars.delete();
         for (int k = 0; k < s.len(); k++) line_chars.push_back(s[k]);
         send_line();
      end
      // zero byte stops parsing, the rest of the line is ignored
      line_chars = '{"1", "2", 8'h00, "+", "5"};
      send_line();

      while (chars_sent < 1250) begin
         build_line();
         send_line();
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (values_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("sent %0d characters, checked %0d results", chars_sent, values_checked);
      $display("operators exercised (rem..none): %b", operators_seen);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // result side stall pattern, with one long hold-off to back up the input
   initial begin
      int mode;
      int span;
      int held;
      wait (reset == 1'b0);
      repeat (150) begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
      held = 0;
      while (held < 400) begin
         @(posedge clock);
         rsp_stall <= 1'b1;
         held++;
      end
      forever begin
         mode = $urandom_range(0, 3);
         span = (mode == 3) ? $urandom_range(5, 20) : $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
